// File: sv/scpq_pkg.sv
// Package with shared types and constants of the sorted cost priority queue.
`timescale 1ns / 1ps
package scpq_pkg;
  localparam int Depth = 64;
  localparam int CntW = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_QUERY = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic CFG_POS_TOL = 1'b0;
  localparam logic CFG_COST_TOL = 1'b1;

  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] cost;
    logic [31:0] x;
    logic [31:0] y;
  } node_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic  ins;
    logic  del;
    node_t node;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_OUT  = 2'd2
  } state_t;
endpackage

// File: sv/scpq_cell.sv
// One cell of the sorted row: holds one node and shifts with its neighbors.
`timescale 1ns / 1ps
module scpq_cell (
  input  logic              clk,
  input  scpq_pkg::cell_cmd_t cmd,
  input  logic              here_lb,
  input  logic              left_lb,
  input  logic              at_or_after_rm,
  input  scpq_pkg::node_t   left_node,
  input  scpq_pkg::node_t   right_node,
  output scpq_pkg::node_t   node_r
);
  scpq_pkg::node_t node_nxt;

  always_comb begin
    node_nxt = node_r;
    if (cmd.ins) begin
      if (left_lb) node_nxt = left_node;
      else if (here_lb) node_nxt = cmd.node;
    end else if (cmd.del && at_or_after_rm) begin
      node_nxt = right_node;
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
  end
endmodule

// File: sv/sorted_cost_priority_queue.sv
// Top level of the sorted cost priority queue built as a row of shifting cells.
// Each accepted item passes through a compare state (S_EXEC) and a shift state (S_OUT);
// its result then waits in the output register until taken; the next item is accepted at the edge that takes it.
// No new item is accepted while one is in S_EXEC or S_OUT, or while a held result
// is stalled at the output.
// Reset clears the count, tolerances and control; cell contents stay undefined.
`timescale 1ns / 1ps
module sorted_cost_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_node_tag,
  input  logic [31:0] in_node_cost,
  input  logic signed [31:0] in_node_x,
  input  logic signed [31:0] in_node_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_head_tag,
  output logic [31:0] out_head_cost,
  output logic [6:0]  out_entry_count,
  output logic        out_found,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int D = scpq_pkg::Depth;
  localparam int CW = scpq_pkg::CntW;

  scpq_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] pos_tol_r, cost_tol_r;
  scpq_pkg::node_t req_r;
  logic [2:0] op_r;
  logic [D-1:0] lb_r;
  logic [D-1:0] rm_r;
  logic rm_hit_r, q_hit_r;
  logic [D-1:0] lt;
  logic [D-1:0] lbv;
  logic [D-1:0] rmv;
  logic [D-1:0] ins_after;
  scpq_pkg::node_t cells [D];
  scpq_pkg::cell_cmd_t cmd;
  scpq_pkg::node_t sel;
  logic sel_ok;
  logic acc_in, do_ins, do_del, fnd;
  logic [1:0] st;
  logic [32:0] dx, dy;
  logic [31:0] dc;
  logic hold_r;
  logic res_found_r;
  logic [1:0] res_st_r;

  assign acc_in = in_valid && !in_stall;
  assign in_stall = (state_r != scpq_pkg::S_IDLE) || (hold_r && out_stall);

  // Lower-bound one-hot from the parallel compare of every valid cell.
  always_comb begin
    for (int k = 0; k < D; k++)
      lt[k] = (CW'(k) < cnt_r) && (cells[k].cost < req_r.cost);
    lbv[0] = !lt[0];
    for (int k = 1; k < D; k++)
      lbv[k] = lt[k-1] && !lt[k];
  end

  always_comb begin
    sel = '0;
    sel_ok = 1'b0;
    for (int k = 0; k < D; k++)
      if (lbv[k] && (CW'(k) < cnt_r)) begin
        sel = cells[k];
        sel_ok = 1'b1;
      end
  end

  always_comb begin
    dx = {req_r.x[31], req_r.x} - {sel.x[31], sel.x};
    dy = {req_r.y[31], req_r.y} - {sel.y[31], sel.y};
    if (dx[32]) dx = -dx;
    if (dy[32]) dy = -dy;
    dc = (req_r.cost >= sel.cost) ? req_r.cost - sel.cost : sel.cost - req_r.cost;
  end

  always_comb begin
    rmv[0] = (op_r == scpq_pkg::OP_POP) || lbv[0];
    for (int k = 1; k < D; k++)
      rmv[k] = (op_r == scpq_pkg::OP_POP) || lbv[k] || rmv[k-1];
  end

  // Cells right of the insert point take their left neighbor.
  always_comb begin
    ins_after[0] = 1'b0;
    for (int k = 1; k < D; k++)
      ins_after[k] = ins_after[k-1] || lb_r[k-1];
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      op_r <= in_op;
      req_r <= '{tag: in_node_tag, cost: in_node_cost, x: in_node_x, y: in_node_y};
    end
  end

  // The search runs in S_EXEC on the registered request; shifts commit at the end of S_OUT.
  always_ff @(posedge clk) begin
    if (state_r == scpq_pkg::S_EXEC) begin
      lb_r <= lbv;
      rm_hit_r <= sel_ok && (sel.cost == req_r.cost) && (sel.tag == req_r.tag);
      q_hit_r <= sel_ok && (dx <= {1'b0, pos_tol_r}) && (dy <= {1'b0, pos_tol_r})
                 && (dc <= cost_tol_r);
      rm_r <= rmv;
    end
  end

  always_comb begin
    do_ins = (op_r == scpq_pkg::OP_PUSH) && (cnt_r < CW'(D));
    do_del = ((op_r == scpq_pkg::OP_POP) && (cnt_r != '0))
          || ((op_r == scpq_pkg::OP_REMOVE) && rm_hit_r);
    fnd = ((op_r == scpq_pkg::OP_QUERY) && q_hit_r)
       || ((op_r == scpq_pkg::OP_REMOVE) && rm_hit_r);
    st = scpq_pkg::ST_DONE;
    if ((op_r == scpq_pkg::OP_PUSH) && !do_ins) st = scpq_pkg::ST_FULL;
    if ((op_r == scpq_pkg::OP_POP) && (cnt_r == '0)) st = scpq_pkg::ST_EMPTY;
    cmd.ins = (state_r == scpq_pkg::S_OUT) && do_ins;
    cmd.del = (state_r == scpq_pkg::S_OUT) && do_del;
    cmd.node = req_r;
  end

  for (genvar g = 0; g < D; g++) begin : g_row
    scpq_cell u_cell (
      .clk(clk),
      .cmd(cmd),
      .here_lb(lb_r[g]),
      .left_lb(ins_after[g]),
      .at_or_after_rm(rm_r[g]),
      .left_node(cells[(g == 0) ? 0 : g-1]),
      .right_node(cells[(g == D-1) ? D-1 : g+1]),
      .node_r(cells[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    case (state_r)
      scpq_pkg::S_IDLE: if (acc_in) state_nxt = scpq_pkg::S_EXEC;
      scpq_pkg::S_EXEC: state_nxt = scpq_pkg::S_OUT;
      scpq_pkg::S_OUT: begin
        state_nxt = scpq_pkg::S_IDLE;
        if (op_r == scpq_pkg::OP_CLEAR) cnt_nxt = '0;
        else if (do_ins) cnt_nxt = cnt_r + 1'b1;
        else if (do_del) cnt_nxt = cnt_r - 1'b1;
      end
      default: state_nxt = scpq_pkg::S_IDLE;
    endcase
  end

  assign out_valid = hold_r;
  assign out_head_tag = (cnt_r != '0) ? cells[0].tag : '0;
  assign out_head_cost = (cnt_r != '0) ? cells[0].cost : '0;
  assign out_entry_count = 7'(cnt_r);
  assign out_found = res_found_r;
  assign out_status = res_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scpq_pkg::S_IDLE;
      cnt_r <= '0;
      pos_tol_r <= '0;
      cost_tol_r <= '0;
      hold_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      if (state_r == scpq_pkg::S_OUT) hold_r <= 1'b1;
      else if (hold_r && !out_stall) hold_r <= 1'b0;
      if (cfg_we && cfg_index == scpq_pkg::CFG_POS_TOL) pos_tol_r <= cfg_data;
      if (cfg_we && cfg_index == scpq_pkg::CFG_COST_TOL) cost_tol_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == scpq_pkg::S_OUT) begin
      res_found_r <= fnd;
      res_st_r <= st;
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(D))
    else $error("count above depth");
  a_one_lb: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == scpq_pkg::S_OUT |-> $onehot0(lb_r))
    else $error("insert point not unique");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == scpq_pkg::S_EXEC |=> state_r == scpq_pkg::S_OUT)
    else $error("sequence broken");
endmodule

// File: tb/scpq_checker.sv
// Checker that predicts and compares every result of the sorted cost priority queue.
`timescale 1ns / 1ps
module scpq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_node_tag,
  input  logic [31:0] in_node_cost,
  input  logic [31:0] in_node_x,
  input  logic [31:0] in_node_y,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_head_tag,
  input  logic [31:0] out_head_cost,
  input  logic [6:0]  out_entry_count,
  input  logic        out_found,
  input  logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  typedef struct packed {
    logic [15:0] head_tag;
    logic [31:0] head_cost;
    logic [6:0]  entry_count;
    logic        found;
    logic [1:0]  status;
  } queue_result_t;

  scpq_pkg::node_t held_nodes[scpq_pkg::Depth];
  int             held_num;
  logic [31:0]    pos_tol;
  logic [31:0]    cost_tol;
  queue_result_t  expected_results[$];

  function automatic int find_slot(logic [31:0] cost);
    int lo;
    lo = 0;
    while (lo < held_num && held_nodes[lo].cost < cost) lo++;
    return lo;
  endfunction

  function automatic logic [31:0] signed_distance(logic [31:0] a, logic [31:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    if (d < 0) d = -d;
    return (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
  endfunction

  task automatic apply_item(logic [2:0] op, scpq_pkg::node_t nd);
    queue_result_t r;
    int slot;
    logic [31:0] dc;
    r = '0;
    slot = find_slot(nd.cost);
    case (op)
      scpq_pkg::OP_PUSH: begin
        if (held_num >= scpq_pkg::Depth) begin
          r.status = scpq_pkg::ST_FULL;
        end else begin
          for (int k = held_num; k > slot; k--) held_nodes[k] = held_nodes[k - 1];
          held_nodes[slot] = nd;
          held_num++;
        end
      end
      scpq_pkg::OP_POP: begin
        if (held_num == 0) begin
          r.status = scpq_pkg::ST_EMPTY;
        end else begin
          for (int k = 0; k + 1 < held_num; k++) held_nodes[k] = held_nodes[k + 1];
          held_num--;
        end
      end
      scpq_pkg::OP_QUERY: begin
        if (slot < held_num) begin
          dc = (nd.cost >= held_nodes[slot].cost) ? nd.cost - held_nodes[slot].cost
                                                  : held_nodes[slot].cost - nd.cost;
          if (signed_distance(nd.x, held_nodes[slot].x) <= pos_tol &&
              signed_distance(nd.y, held_nodes[slot].y) <= pos_tol &&
              dc <= cost_tol) r.found = 1'b1;
        end
      end
      scpq_pkg::OP_REMOVE: begin
        if (slot < held_num && held_nodes[slot].cost == nd.cost &&
            held_nodes[slot].tag == nd.tag) begin
          for (int k = slot; k + 1 < held_num; k++) held_nodes[k] = held_nodes[k + 1];
          held_num--;
          r.found = 1'b1;
        end
      end
      scpq_pkg::OP_CLEAR: held_num = 0;
      default: ;
    endcase
    if (held_num > 0) begin
      r.head_tag = held_nodes[0].tag;
      r.head_cost = held_nodes[0].cost;
    end
    r.entry_count = held_num[6:0];
    expected_results.push_back(r);
  endtask

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    queue_result_t want;
    queue_result_t got;
    scpq_pkg::node_t nd;
    if (!rst_n) begin
      held_num = 0;
      pos_tol = '0;
      cost_tol = '0;
      expected_results.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == scpq_pkg::CFG_POS_TOL) pos_tol = cfg_data;
        else cost_tol = cfg_data;
      end
      if (out_valid && !out_stall) begin
        got = '{out_head_tag, out_head_cost, out_entry_count, out_found, out_status};
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: expected %p actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        nd = '{in_node_tag, in_node_cost, in_node_x, in_node_y};
        apply_item(in_op, nd);
      end
    end
  end
endmodule

// File: tb/tb_top.sv
// Testbench top that drives the sorted cost priority queue and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_op;
  logic [15:0] in_node_tag;
  logic [31:0] in_node_cost;
  logic [31:0] in_node_x;
  logic [31:0] in_node_y;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_head_tag;
  logic [31:0] out_head_cost;
  logic [6:0]  out_entry_count;
  logic        out_found;
  logic [1:0]  out_status;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending_count;
  int          result_count;
  int          cycle_count = 0;
  int          sent_count;
  bit          hold_off;
  bit          stall_free;
  bit          in_taken;
  logic [31:0] recent_costs[$];
  logic [15:0] recent_tags[$];

  sorted_cost_priority_queue u_top (.*);
  scpq_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) in_taken <= in_valid && !in_stall;

  // Receiver stall pattern, with a long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end else if (stall_free) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send_item(logic [2:0] op, logic [15:0] tag, logic [31:0] cost,
                           logic [31:0] x, logic [31:0] y);
    in_valid <= 1'b1;
    in_op <= op;
    in_node_tag <= tag;
    in_node_cost <= cost;
    in_node_x <= x;
    in_node_y <= y;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
    sent_count++;
    if (op == scpq_pkg::OP_PUSH) begin
      recent_costs.push_back(cost);
      recent_tags.push_back(tag);
      if (recent_costs.size() > 32) begin
        void'(recent_costs.pop_front());
        void'(recent_tags.pop_front());
      end
    end
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 4)) @(negedge clk);
  endtask

  task automatic drain_and_write(logic idx, logic [31:0] value);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int pick;
    logic [31:0] c;
    logic [15:0] t;
    int j;
    pick = $urandom_range(0, 99);
    c = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 40) << 14;
    t = $urandom();
    if (pick < 45) begin
      send_item(scpq_pkg::OP_PUSH, t, c, $urandom(), $urandom());
    end else if (pick < 62) begin
      send_item(scpq_pkg::OP_POP, t, c, $urandom(), $urandom());
    end else if (pick < 78) begin
      if (recent_costs.size() > 0 && $urandom_range(0, 2) != 0) begin
        j = $urandom_range(0, recent_costs.size() - 1);
        c = recent_costs[j] + $urandom_range(0, 2) - 1;
      end
      send_item(scpq_pkg::OP_QUERY, t, c, $urandom_range(0, 3) << 16,
                $urandom_range(0, 3) << 16);
    end else if (pick < 96) begin
      if (recent_costs.size() > 0 && $urandom_range(0, 3) != 0) begin
        j = $urandom_range(0, recent_costs.size() - 1);
        c = recent_costs[j];
        t = ($urandom_range(0, 4) == 0) ? t : recent_tags[j];
      end
      send_item(scpq_pkg::OP_REMOVE, t, c, $urandom(), $urandom());
    end else if (pick < 98) begin
      send_item(scpq_pkg::OP_CLEAR, t, c, $urandom(), $urandom());
    end else begin
      send_item(3'($urandom_range(5, 7)), t, c, $urandom(), $urandom());
    end
  endtask

  task automatic random_phase(int count);
    int burst;
    int done;
    done = 0;
    while (done < count) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && done < count; k++) begin
        random_item();
        done++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = scpq_pkg::OP_PUSH;
    in_node_tag = '0;
    in_node_cost = '0;
    in_node_x = '0;
    in_node_y = '0;
    cfg_we = 1'b0;
    cfg_index = scpq_pkg::CFG_POS_TOL;
    cfg_data = '0;
    hold_off = 1'b0;
    stall_free = 1'b0;
    sent_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty queue cases, then extremes, ties, exact matches and undefined opcodes.
    send_item(scpq_pkg::OP_POP, 16'h0, 32'h0, 32'h0, 32'h0);
    send_item(scpq_pkg::OP_QUERY, 16'h0, 32'h0, 32'h0, 32'h0);
    send_item(scpq_pkg::OP_REMOVE, 16'h0, 32'h0, 32'h0, 32'h0);
    send_item(scpq_pkg::OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(scpq_pkg::OP_PUSH, 16'h0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(scpq_pkg::OP_PUSH, 16'h0011, 32'h0001_0000, 32'h0, 32'h0);
    send_item(scpq_pkg::OP_PUSH, 16'h0022, 32'h0001_0000, 32'h0, 32'h0);
    send_item(scpq_pkg::OP_QUERY, 16'h0, 32'h0001_0000, 32'h0, 32'h0);
    send_item(scpq_pkg::OP_QUERY, 16'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(scpq_pkg::OP_REMOVE, 16'h0011, 32'h0001_0000, 32'h0, 32'h0);
    send_item(scpq_pkg::OP_REMOVE, 16'h0011, 32'h0001_0000, 32'h0, 32'h0);
    send_item(scpq_pkg::OP_REMOVE, 16'h0022, 32'h0001_0000, 32'h0, 32'h0);
    send_item(3'd5, 16'h1, 32'h1, 32'h1, 32'h1);
    send_item(3'd7, 16'h1, 32'h1, 32'h1, 32'h1);
    send_item(scpq_pkg::OP_POP, 16'h0, 32'h0, 32'h0, 32'h0);
    send_item(scpq_pkg::OP_CLEAR, 16'h0, 32'h0, 32'h0, 32'h0);

    // Fill past capacity, starting under a long receiver hold-off.
    hold_off = 1'b1;
    for (int k = 0; k < scpq_pkg::Depth + 3; k++)
      send_item(scpq_pkg::OP_PUSH, 16'($urandom()), $urandom_range(0, 15) << 16,
                $urandom(), $urandom());
    drain_and_write(scpq_pkg::CFG_POS_TOL, 32'hFFFF_FFFF);
    drain_and_write(scpq_pkg::CFG_COST_TOL, 32'hFFFF_FFFF);
    send_item(scpq_pkg::OP_QUERY, 16'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(scpq_pkg::OP_CLEAR, 16'h0, 32'h0, 32'h0, 32'h0);

    drain_and_write(scpq_pkg::CFG_POS_TOL, 32'h0002_0000);
    drain_and_write(scpq_pkg::CFG_COST_TOL, 32'h0000_8000);
    stall_free = 1'b1;
    random_phase(150);
    stall_free = 1'b0;
    random_phase(150);
    drain_and_write(scpq_pkg::CFG_POS_TOL, 32'h0);
    drain_and_write(scpq_pkg::CFG_COST_TOL, 32'h0);
    random_phase(200);
    drain_and_write(scpq_pkg::CFG_POS_TOL, $urandom());
    drain_and_write(scpq_pkg::CFG_COST_TOL, $urandom_range(0, 4) << 14);
    random_phase(250);

    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Sent %0d items and checked %0d results over four tolerance settings,",
             sent_count, result_count);
    $display("including a full queue under a long output hold-off.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: files.f
sv/scpq_pkg.sv
sv/scpq_cell.sv
sv/sorted_cost_priority_queue.sv
tb/scpq_checker.sv
tb/tb_top.sv
